[sv/pbfs_pkg.sv]
// shared types and constants of the packed bit-field store
`default_nettype none
package pbfs_pkg;
    localparam int unsigned SEGMENT_WORDS_DEF = 512;
    localparam int unsigned MEM_WORDS_DEF     = 65536;
    localparam int unsigned WORD_BITS         = 64;
    localparam int unsigned VALUE_W           = 32;
    localparam int unsigned KEY_W             = 32;
    localparam int unsigned WIDTH_REG_W       = 6;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned CFG_DATA_W        = 32;
    localparam int unsigned QUO_STEPS         = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 6'd32;
    localparam logic [KEY_W-1:0]       MAX_RST   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clr;
        logic load;
        logic div_key;
        logic mul;
        logic addr;
        logic chk;
        logic rd_lo;
        logic cap_lo;
        logic rd_hi;
        logic cap_hi;
        logic wr_lo;
        logic wr_hi;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic is_write;
        logic ok;
        logic spill;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

[sv/pbfs_in_if.sv]
// request channel: command, key and value words
`default_nettype none
interface pbfs_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [pbfs_pkg::KEY_W-1:0]    key;
    logic [pbfs_pkg::VALUE_W-1:0]  value;
    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface
`default_nettype wire

[sv/pbfs_out_if.sv]
// read result channel
`default_nettype none
interface pbfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [pbfs_pkg::VALUE_W-1:0]  read_value;
    logic                          out_of_range;
    modport source (output valid, read_value, out_of_range, input ready);
    modport sink   (input valid, read_value, out_of_range, output ready);
endinterface
`default_nettype wire

[sv/pbfs_ctrl.sv]
// sequencing state machine of the packed bit-field store
`default_nettype none
module pbfs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  pbfs_pkg::t_sts      i_sts,
    output pbfs_pkg::t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_ADDR, S_CHK, S_DEC,
        S_RDHI, S_CAPHI, S_WRLO, S_WRHI, S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV1;
                end
            end
            S_DIV1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_key = 1'b1;
                    n_state       = S_DIV2;
                end
            end
            S_DIV2: begin
                if (!i_sts.div_busy) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                if (i_sts.ok) begin
                    o_cmd.rd_lo = 1'b1;
                    n_state     = S_RDHI;
                end else if (i_sts.is_write) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_RDHI: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_hi  = 1'b1;
                n_state      = S_CAPHI;
            end
            S_CAPHI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = i_sts.is_write ? S_WRLO : S_RESULT;
            end
            S_WRLO: begin
                o_cmd.wr_lo = 1'b1;
                n_state     = i_sts.spill ? S_WRHI : S_IDLE;
            end
            S_WRHI: begin
                o_cmd.wr_hi = 1'b1;
                n_state     = S_IDLE;
            end
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_ready) else $error("load without ready");
    a_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> !r_ready) else $error("ready right after load");
endmodule
`default_nettype wire

[sv/pbfs_dp.sv]
// datapath: config, divider, address math, word store and result register
`default_nettype none
module pbfs_dp #(
    parameter int unsigned SEGMENT_WORDS = pbfs_pkg::SEGMENT_WORDS_DEF,
    parameter int unsigned MEM_WORDS     = pbfs_pkg::MEM_WORDS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [pbfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [pbfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_command,
    input  wire  [pbfs_pkg::KEY_W-1:0]          i_key,
    input  wire  [pbfs_pkg::VALUE_W-1:0]        i_value,
    input  pbfs_pkg::t_cmd                      i_cmd,
    output pbfs_pkg::t_sts                      o_sts,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [pbfs_pkg::VALUE_W-1:0]        o_read_value,
    output logic                                o_out_of_range
);
    localparam int unsigned SegBits = SEGMENT_WORDS * 64;
    localparam int unsigned SlW     = $clog2(SegBits + 1);
    localparam int unsigned SwW     = $clog2(SEGMENT_WORDS + 1);
    localparam int unsigned WaW     = 32 + SwW + 1;
    localparam int unsigned MaW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int unsigned CcW     = $clog2(MEM_WORDS + 1);
    localparam int unsigned BpW     = SlW + 6;
    localparam int unsigned QcW     = $clog2(pbfs_pkg::QUO_STEPS + 1);
    localparam int unsigned WB      = pbfs_pkg::WORD_BITS;
    localparam int unsigned VW      = pbfs_pkg::VALUE_W;

    // configuration
    logic [pbfs_pkg::WIDTH_REG_W-1:0] r_vw;
    logic [pbfs_pkg::KEY_W-1:0]       r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vw  <= pbfs_pkg::WIDTH_RST;
            r_max <= pbfs_pkg::MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbfs_pkg::CFG_VALUE_WIDTH: r_vw  <= i_cfg_data[pbfs_pkg::WIDTH_REG_W-1:0];
                pbfs_pkg::CFG_MAX_ENTRIES: r_max <= i_cfg_data[pbfs_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // effective width and mask
    logic [pbfs_pkg::WIDTH_REG_W-1:0] eff_w;
    logic [VW-1:0]                    eff_mask;
    always_comb begin
        if (r_vw == '0) begin
            eff_w = 6'd1;
        end else if (r_vw > 6'd32) begin
            eff_w = 6'd32;
        end else begin
            eff_w = r_vw;
        end
        eff_mask = (eff_w == 6'd32) ? '1 : ((32'h1 << eff_w[4:0]) - 32'h1);
    end

    // captured request
    logic                             r_write, r_key_ok;
    logic [pbfs_pkg::KEY_W-1:0]       r_key;
    logic [VW-1:0]                    r_val, r_mask;
    logic [pbfs_pkg::WIDTH_REG_W-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_write  <= (i_command == pbfs_pkg::CMD_WRITE);
            r_key    <= i_key;
            r_key_ok <= (i_key < r_max);
            r_val    <= i_value & eff_mask;
            r_mask   <= eff_mask;
            r_w      <= eff_w;
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [31:0]    r_quo;
    logic [SlW-1:0] r_rem, r_dsr;
    logic [QcW-1:0] r_qcnt;
    logic [SlW:0]   rem_sh, rem_diff;
    assign rem_sh   = {r_rem, r_quo[31]};
    assign rem_diff = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= '0;
        end else if (i_cmd.load || i_cmd.div_key) begin
            r_qcnt <= QcW'(pbfs_pkg::QUO_STEPS);
        end else if (r_qcnt != '0) begin
            r_qcnt <= r_qcnt - QcW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // slots per segment = segment bits / width
            r_quo <= 32'(SegBits);
            r_dsr <= SlW'(eff_w);
            r_rem <= '0;
        end else if (i_cmd.div_key) begin
            r_quo <= r_key;
            r_dsr <= r_quo[SlW-1:0];
            r_rem <= '0;
        end else if (r_qcnt != '0) begin
            if (!rem_diff[SlW]) begin
                r_rem <= rem_diff[SlW-1:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[SlW-1:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    // address math
    logic [BpW-1:0] r_bitpos;
    logic [WaW-1:0] r_segbase, r_word;
    logic [5:0]     r_off;
    logic           r_spill, r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_bitpos  <= BpW'(r_rem) * BpW'(r_w);
            r_segbase <= WaW'(r_quo) * WaW'(SEGMENT_WORDS);
        end
        if (i_cmd.addr) begin
            r_word  <= r_segbase + WaW'(r_bitpos >> 6);
            r_off   <= r_bitpos[5:0];
            r_spill <= (7'(r_bitpos[5:0]) + 7'(r_w)) > 7'd64;
        end
        if (i_cmd.chk) begin
            r_ok <= r_key_ok && ((r_word + WaW'(r_spill)) < WaW'(MEM_WORDS));
        end
    end

    // word store with clearing sweep
    logic [WB-1:0]  mem [MEM_WORDS];
    logic [WB-1:0]  r_rdata, r_lo, r_hi, mem_wdata;
    logic [CcW-1:0] r_clr_cnt;
    logic [MaW-1:0] mem_addr, addr_lo, addr_hi;
    logic           mem_we, mem_re;
    logic [2*WB-1:0] pair, fmask, fval, merged, shifted;

    assign addr_lo = r_word[MaW-1:0];
    assign addr_hi = addr_lo + MaW'(1);
    assign pair    = {r_hi, r_lo};
    assign fmask   = {{(2*WB-VW){1'b0}}, r_mask} << r_off;
    assign fval    = {{(2*WB-VW){1'b0}}, r_val} << r_off;
    assign merged  = (pair & ~fmask) | fval;
    assign shifted = pair >> r_off;

    always_comb begin
        mem_addr  = addr_lo;
        mem_wdata = merged[WB-1:0];
        mem_we    = 1'b0;
        mem_re    = i_cmd.rd_lo || i_cmd.rd_hi;
        if (i_cmd.clr) begin
            mem_addr  = r_clr_cnt[MaW-1:0];
            mem_wdata = '0;
            mem_we    = 1'b1;
        end else if (i_cmd.wr_lo) begin
            mem_we = 1'b1;
        end else if (i_cmd.wr_hi) begin
            mem_addr  = addr_hi;
            mem_wdata = merged[2*WB-1:WB];
            mem_we    = 1'b1;
        end else if (i_cmd.rd_hi) begin
            mem_addr = addr_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + CcW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_lo) begin
            r_lo <= r_rdata;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= r_rdata;
        end
    end

    // result register
    logic          r_out_valid, r_oor;
    logic [VW-1:0] r_out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_val <= r_ok ? (shifted[VW-1:0] & r_mask) : '0;
            r_oor     <= !r_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_val;
    assign o_out_of_range = r_oor;

    always_comb begin
        o_sts.clr_done = (r_clr_cnt == CcW'(MEM_WORDS));
        o_sts.div_busy = (r_qcnt != '0);
        o_sts.is_write = r_write;
        o_sts.ok       = r_ok;
        o_sts.spill    = r_spill;
        o_sts.out_busy = r_out_valid;
    end

    a_hi_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_hi |-> r_spill) else $error("second word written without spill");
    a_mem_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_lo || i_cmd.wr_lo) |-> r_ok) else $error("access out of range");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid) else $error("result overwritten");
endmodule
`default_nettype wire

[sv/packed_bit_field_store.sv]
// top level of the packed bit-field store
`default_nettype none
// Packed bit-field store: values of 1 to 32 bits (width register) are packed
// into 64-bit words inside segments of SEGMENT_WORDS words, never crossing a
// segment edge. A request word carries a command (read or write), a key and
// a value. Reads return one result word; writes return none. Keys at or
// above max_entries, or whose field would reach past MEM_WORDS, read as zero
// with out_of_range set and are not written. After reset the store is swept
// to zero, one word per cycle, before the first request is taken;
// configuration writes are taken at any time. One request is in work at a
// time. Each request runs two 32-step quotient passes of the shared divider
// (slots per segment, then key by slots); an in-range request then reads the
// one-port word store, and a write writes back one word, or two when the
// field spans two words. The next request can be taken while a result still
// waits in the output register.
module packed_bit_field_store #(
    parameter int unsigned SEGMENT_WORDS = pbfs_pkg::SEGMENT_WORDS_DEF,
    parameter int unsigned MEM_WORDS     = pbfs_pkg::MEM_WORDS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [pbfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [pbfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pbfs_in_if.sink                          i_in,
    pbfs_out_if.source                       o_out
);
    pbfs_pkg::t_cmd cmd;
    pbfs_pkg::t_sts sts;
    logic           in_ready;

    // controller: sweep, divider passes, address steps, word access
    pbfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    // datapath: config registers, divider, store, result register
    pbfs_dp #(
        .SEGMENT_WORDS (SEGMENT_WORDS),
        .MEM_WORDS     (MEM_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_in.command),
        .i_key          (i_in.key),
        .i_value        (i_in.value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_read_value   (o_out.read_value),
        .o_out_of_range (o_out.out_of_range)
    );
endmodule
`default_nettype wire

[test/tb.sv]
// testbench of the packed bit-field store: self-predicting scoreboard with directed and random traffic
`default_nettype none
module tb;
    import pbfs_pkg::*;

    localparam int unsigned SEG_W   = SEGMENT_WORDS_DEF;
    localparam int unsigned MEM_W   = MEM_WORDS_DEF;
    localparam int          LIMIT   = 200000;   // cycles without any handshake (covers clear sweep)
    localparam int          N_RAND  = 550;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               out_of_range;
    } t_rd_result;

    // predictor of the packed store, holds its own copy of memory and registers
    class store_scoreboard;
        bit [63:0]          words[int unsigned];
        bit [WIDTH_REG_W-1:0] width_reg;
        bit [KEY_W-1:0]     max_keys;
        t_rd_result         pending[$];
        int                 errors;

        function new();
            width_reg = WIDTH_RST;
            max_keys  = MAX_RST;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_VALUE_WIDTH) width_reg = d[WIDTH_REG_W-1:0];
            else if (idx == CFG_MAX_ENTRIES) max_keys = d;
        endfunction

        function bit [63:0] peek(longint unsigned a);
            if (words.exists(a)) return words[a];
            return 64'd0;
        endfunction

        // note an accepted request word, updating store and expected results
        function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
            int unsigned      w;
            bit [63:0]        mask, v, lo, hi;
            longint unsigned  slots, seg, slot, bitpos, addr;
            int unsigned      off;
            bit               ok, spill;
            t_rd_result       r;
            w = (width_reg < 1) ? 1 : (width_reg > 32) ? 32 : width_reg;
            mask = (64'd1 << w) - 1;
            ok = key < max_keys;
            addr = 0; off = 0;
            if (ok) begin
                slots  = (longint'(SEG_W) * 64) / w;
                seg    = key / slots;
                slot   = key % slots;
                bitpos = slot * w;
                addr   = seg * SEG_W + (bitpos >> 6);
                off    = bitpos & 63;
                if (addr + ((off + w > 64) ? 1 : 0) >= MEM_W) ok = 0;
            end
            spill = ok && (off + w > 64);
            if (cmd == CMD_WRITE) begin
                if (ok) begin
                    v = val & mask;
                    words[addr] = (peek(addr) & ~(mask << off)) | (v << off);
                    if (spill)
                        words[addr+1] = (peek(addr+1) & ~(mask >> (64 - off)))
                                        | (v >> (64 - off));
                end
                return;
            end
            if (!ok) begin
                r.read_value = '0; r.out_of_range = 1'b1;
            end else begin
                lo = peek(addr) >> off;
                if (spill) begin
                    hi = peek(addr+1) << (64 - off);
                    lo |= hi;
                end
                lo &= mask;
                r.read_value = lo[VALUE_W-1:0];
                r.out_of_range = 1'b0;
            end
            pending.push_back(r);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(logic [VALUE_W-1:0] rv, logic oor);
            t_rd_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h oor=%b", $time, rv, oor);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (rv !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value, rv);
                errors++;
            end
            if (oor !== e.out_of_range) begin
                $display("%0t: out_of_range expected %b actual %b", $time, e.out_of_range, oor);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pbfs_in_if  req_ch();
    pbfs_out_if res_ch();

    packed_bit_field_store u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (req_ch.sink),
        .o_out      (res_ch.source)
    );

    store_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;       // long receiver stall requested by the stimulus
    bit  stim_done;
    int  words_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // every input at a known value from time zero
    initial begin
        sb = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        req_ch.valid = 1'b0; req_ch.command = CMD_READ; req_ch.key = '0; req_ch.value = '0;
        res_ch.ready = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        words_sent = 0;
    end

    // request and result handshakes, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.command, req_ch.key, req_ch.value);
            words_sent <= words_sent + 1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.read_value, res_ch.out_of_range);
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // receiver: own stall pattern in runs of ready, stall or random ready, plus requested long hold-off
    initial begin : receiver
        int mode;
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 40);
            repeat (n) begin
                res_ch.ready <= (mode == 0) ? 1'b1 :
                                (mode == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
                @(posedge i_clk);
            end
        end
    end

    // offer one request word and hold it until taken
    task automatic send_word(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.key     <= key;
        req_ch.value   <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_sender();
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge i_clk);
    endtask

    // burst-wise sender: random burst length, with a random gap before most bursts
    int burst_left = 0;
    task automatic send_bursty(logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] val);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) != 0) pause_sender();
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        send_word(cmd, key, val);
    endtask

    // let the block drain, then write a register while it is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);   // a trailing write may still be in work
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
        cfg_we <= 1'b0;
    endtask

    // key biased toward the low slots so reads hit written data
    function automatic logic [KEY_W-1:0] pick_key(int unsigned span);
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 40);
            default: return $urandom_range(0, span);
        endcase
    endfunction

    initial begin : stimulus
        int unsigned widths[6];
        int unsigned span;
        logic [KEY_W-1:0] k;
        widths = '{1, 32, 7, 13, 0, 63};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset width 32, extremes of key and value
        send_word(CMD_WRITE, 32'd0, 32'hFFFF_FFFF);
        send_word(CMD_READ,  32'd0, 32'd0);
        send_word(CMD_WRITE, 32'd1, 32'hA5A5_5A5A);
        send_word(CMD_READ,  32'd1, 32'hFFFF_FFFF);
        send_word(CMD_READ,  32'hFFFF_FFFF, 32'd0);   // beyond memory
        send_word(CMD_WRITE, 32'hFFFF_FFFF, 32'd5);   // ignored write
        send_word(CMD_READ,  32'd131071, 32'd0);      // last slot in memory
        send_word(CMD_READ,  32'd131072, 32'd0);      // just past memory
        // width 13 spills over word edges
        write_reg(CFG_VALUE_WIDTH, 32'd13);
        send_word(CMD_WRITE, 32'd4, 32'hFFFF_FFFF);   // bits 52..64, spills
        send_word(CMD_READ,  32'd4, 32'd0);
        send_word(CMD_READ,  32'd5, 32'd0);
        send_word(CMD_WRITE, 32'd2519, 32'h1234);     // last slot of segment 0
        send_word(CMD_READ,  32'd2520, 32'd0);        // first of segment 1
        send_word(CMD_READ,  32'd2519, 32'd0);
        // entry limit, both extremes
        write_reg(CFG_MAX_ENTRIES, 32'd10);
        send_word(CMD_READ,  32'd9, 32'd0);
        send_word(CMD_READ,  32'd10, 32'd0);
        send_word(CMD_WRITE, 32'd10, 32'd1);
        write_reg(CFG_MAX_ENTRIES, 32'd0);
        send_word(CMD_READ,  32'd0, 32'd0);
        write_reg(CFG_MAX_ENTRIES, 32'hFFFF_FFFF);
        // long receiver stall while the sender keeps offering
        hold_off = 1'b1;
        repeat (6) send_word(CMD_READ, $urandom_range(0, 8), 32'd0);

        // random phases across width settings, clamped values included
        foreach (widths[p]) begin
            write_reg(CFG_VALUE_WIDTH, widths[p]);
            if (p == 3) write_reg(CFG_MAX_ENTRIES, $urandom_range(50, 3000));
            if (p == 4) write_reg(CFG_MAX_ENTRIES, 32'hFFFF_FFFF);
            span = (p == 0) ? 600 : 200;
            repeat (N_RAND / 6) begin
                k = pick_key(span);
                send_bursty($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, k, $urandom());
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
